### rtl/ssc_pkg.sv
// Shared types, constants and glyph table for the seven-segment scan controller.
package ssc_pkg;

   localparam int NUM_DIGITS = 8;
   localparam int POS_W      = 3;
   localparam int CODE_W     = 4;
   localparam int SEG_W      = 7;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CODE_W-1:0] CODE_BLANK = 4'd12;

   localparam logic [TICK_W-1:0] BLANK_TICKS_RST = 16'd16;
   localparam logic [TICK_W-1:0] SETUP_TICKS_RST = 16'd16;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RST  = 16'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETUP_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS  = 2'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [2:0] {
      PH_BLANK = 3'b001,
      PH_SETUP = 3'b010,
      PH_HOLD  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] blank_ticks;
      logic [TICK_W-1:0] setup_ticks;
      logic [TICK_W-1:0] hold_ticks;
   } timing_type;

   typedef struct packed {
      logic [POS_W-1:0] digit_index;
      logic             digit_enable;
      logic [SEG_W-1:0] segments;
   } drive_type;

   function automatic logic [SEG_W-1:0] glyph_segments(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] seg;
      case (code)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         4'd10:   seg = 7'h40;
         4'd11:   seg = 7'h79;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

### rtl/seven_segment_scan_controller.sv
// Top level: config registers, digit store, scan engine and result register.
//
//   channel  direction  word                                   handshake
//   req_     in         tuser: opcode; tdata: position, glyph  req_tvalid/req_tready
//   rsp_     out        tdata: segments, enable, index         rsp_tvalid/rsp_tready
//   csr_     in         csr_index, csr_data                    csr_valid/csr_ready
//
// One word in per cycle while req_tready is high; each result appears in the
// cycle after its word is taken, set by the single result register. reset
// restores timings 16/16/1024, blanks all digits and returns the scan to
// position 0, blanking phase. A stalled result holds; req_tready drops only
// while the result register is full and not being taken. csr_ready is always high.
module seven_segment_scan_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // digit_position[2:0], glyph_code[6:3], 0
   input  logic                            req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,  // segments[6:0], digit_enable[7], digit_index[10:8], 0
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssc_pkg::TICK_W-1:0]      csr_data
);
   import ssc_pkg::*;

   timing_type       timing_ff;
   drive_type        drive;
   drive_type        rsp_data_ff;
   logic             rsp_valid_ff;
   logic             req_fire;
   logic             tick_en;
   logic             wr_en;
   logic [POS_W-1:0] rd_pos;
   logic [CODE_W-1:0] rd_code;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign tick_en    = req_fire && (req_tuser == OP_TICK);
   assign wr_en      = req_fire && (req_tuser == OP_WRITE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.blank_ticks <= BLANK_TICKS_RST;
         timing_ff.setup_ticks <= SETUP_TICKS_RST;
         timing_ff.hold_ticks  <= HOLD_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLANK_TICKS: timing_ff.blank_ticks <= csr_data;
            CSR_SETUP_TICKS: timing_ff.setup_ticks <= csr_data;
            CSR_HOLD_TICKS:  timing_ff.hold_ticks  <= csr_data;
            default: ;
         endcase
      end
   end

   ssc_digit_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_pos  (req_tdata[2:0]),
      .wr_code (req_tdata[6:3]),
      .rd_pos  (rd_pos),
      .rd_code (rd_code)
   );

   ssc_scan_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .timing  (timing_ff),
      .rd_code (rd_code),
      .rd_pos  (rd_pos),
      .drive   (drive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= drive;
      end
   end

`ifndef SYNTH
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted word produced no result");

   a_index_zero_when_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_data_ff.digit_enable) |-> (rsp_data_ff.digit_index == '0))
      else $error("digit index nonzero while no digit selected");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while result register is stalled");
`endif

endmodule

### rtl/ssc_digit_store.sv
// Glyph code store, one register per digit position, reset to blank.
module ssc_digit_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ssc_pkg::POS_W-1:0]   wr_pos,
   input  logic [ssc_pkg::CODE_W-1:0]  wr_code,
   input  logic [ssc_pkg::POS_W-1:0]   rd_pos,
   output logic [ssc_pkg::CODE_W-1:0]  rd_code
);
   import ssc_pkg::*;

   logic [CODE_W-1:0] store_ff [NUM_DIGITS];
   logic              pos_ok;

   assign pos_ok  = ({1'b0, wr_pos} < (POS_W+1)'(NUM_DIGITS));
   assign rd_code = store_ff[rd_pos];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            store_ff[i] <= CODE_BLANK;
         end
      end else if (wr_en && pos_ok) begin
         store_ff[wr_pos] <= wr_code;
      end
   end

endmodule

### rtl/ssc_scan_engine.sv
// Scan timer: phase state machine, phase counter, position and segment latch.
module ssc_scan_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_en,
   input  ssc_pkg::timing_type         timing,
   input  logic [ssc_pkg::CODE_W-1:0]  rd_code,
   output logic [ssc_pkg::POS_W-1:0]   rd_pos,
   output ssc_pkg::drive_type          drive
);
   import ssc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SEG_W-1:0]  latch_ff, latch_in;
   logic [TICK_W-1:0] len_raw, len_eff;
   logic [TICK_W:0]   count_inc;
   logic              phase_done;
   logic              load;

   assign rd_pos = pos_ff;
   assign load   = tick_en && (phase_ff == PH_SETUP) && (count_ff == '0);

   always_comb begin
      unique case (phase_ff)
         PH_SETUP: len_raw = timing.setup_ticks;
         PH_HOLD:  len_raw = timing.hold_ticks;
         default:  len_raw = timing.blank_ticks;
      endcase
   end

   assign len_eff    = (len_raw == '0) ? TICK_W'(1) : len_raw;
   assign count_inc  = {1'b0, count_ff} + (TICK_W+1)'(1);
   assign phase_done = (count_inc >= {1'b0, len_eff});

   // show the glyph on the first setup tick already
   always_comb begin
      latch_in = load ? glyph_segments(rd_code) : latch_ff;
      drive.segments     = latch_in;
      drive.digit_enable = (phase_ff == PH_HOLD);
      drive.digit_index  = (phase_ff == PH_HOLD) ? pos_ff : '0;
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      count_in = phase_done ? '0 : count_inc[TICK_W-1:0];
      if (phase_done) begin
         unique case (phase_ff)
            PH_BLANK: phase_in = PH_SETUP;
            PH_SETUP: phase_in = PH_HOLD;
            PH_HOLD: begin
               phase_in = PH_BLANK;
               pos_in   = ({1'b0, pos_ff} >= (POS_W+1)'(NUM_DIGITS - 1)) ? '0
                                                                        : pos_ff + 1'b1;
            end
            default: phase_in = PH_BLANK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BLANK;
         count_ff <= '0;
         pos_ff   <= '0;
         latch_ff <= '0;
      end else if (tick_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         latch_ff <= latch_in;
      end
   end

endmodule

### bench/tb_seven_segment_scan_controller.sv
// Self-checking testbench for the seven-segment scan controller: glyph writes and scan ticks.
module tb_seven_segment_scan_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import ssc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;

   // Segment patterns for codes 15 down to 0; codes 12-15 stay dark.
   localparam logic [16*SEG_W-1:0] GLYPH_SEGS = {
      7'h00, 7'h00, 7'h00, 7'h00, 7'h79, 7'h40, 7'h6F, 7'h7F,
      7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;  // digit_position[2:0], glyph_code[6:3], 0
   logic                 req_tuser  = 1'b0;  // opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;  // segments[6:0], digit_enable[7], digit_index[10:8], 0
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [TICK_W-1:0]    csr_data   = '0;

   seven_segment_scan_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scanner state as the block should hold it
   timing_type        scan_timing;
   logic [CODE_W-1:0] glyph_store [NUM_DIGITS];
   phase_type         scan_phase;
   int unsigned       phase_ticks;
   logic [POS_W-1:0]  scan_pos;
   logic [SEG_W-1:0]  seg_latch;

   drive_type   pending_drives [$];
   drive_type   want_drive;
   drive_type   got_drive;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   bit          gaps_on     = 1'b1;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned rx_cycle     = 0;
   int unsigned rx_style     = 0;

   function automatic drive_type next_drive(input logic op, input logic [POS_W-1:0] pos,
                                            input logic [CODE_W-1:0] code);
      drive_type   d;
      int unsigned len;
      if (op == OP_WRITE) begin
         glyph_store[pos] = code;
      end else if (scan_phase == PH_SETUP && phase_ticks == 0) begin
         seg_latch = GLYPH_SEGS[glyph_store[scan_pos]*SEG_W +: SEG_W];
      end
      d.segments     = seg_latch;
      d.digit_enable = (scan_phase == PH_HOLD);
      d.digit_index  = (scan_phase == PH_HOLD) ? scan_pos : '0;
      if (op == OP_TICK) begin
         phase_ticks++;
         case (scan_phase)
            PH_SETUP: len = scan_timing.setup_ticks;
            PH_HOLD:  len = scan_timing.hold_ticks;
            default:  len = scan_timing.blank_ticks;
         endcase
         if (len == 0) len = 1;
         if (phase_ticks >= len) begin
            phase_ticks = 0;
            case (scan_phase)
               PH_BLANK: scan_phase = PH_SETUP;
               PH_SETUP: scan_phase = PH_HOLD;
               default: begin
                  scan_phase = PH_BLANK;
                  scan_pos   = (scan_pos == NUM_DIGITS - 1) ? '0 : scan_pos + 1'b1;
               end
            endcase
         end
      end
      return d;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
      $display("mismatch in %s: expected 0x%0h, got 0x%0h (cycle %0d)", what, want, got,
               cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_drives.size());
         $display("tb_seven_segment_scan_controller: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_drive = rsp_tdata[10:0];
            if (pending_drives.size() == 0) begin
               flag_mismatch("result with none pending", 0, rsp_tdata);
            end else begin
               want_drive = pending_drives.pop_front();
               if (got_drive.segments !== want_drive.segments)
                  flag_mismatch("segments", want_drive.segments, got_drive.segments);
               if (got_drive.digit_enable !== want_drive.digit_enable)
                  flag_mismatch("digit_enable", want_drive.digit_enable, got_drive.digit_enable);
               if (got_drive.digit_index !== want_drive.digit_index)
                  flag_mismatch("digit_index", want_drive.digit_index, got_drive.digit_index);
            end
         end
         if (req_tvalid && req_tready)
            pending_drives.push_back(next_drive(req_tuser, req_tdata[2:0], req_tdata[6:3]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BLANK_TICKS: scan_timing.blank_ticks = csr_data;
               CSR_SETUP_TICKS: scan_timing.setup_ticks = csr_data;
               CSR_HOLD_TICKS:  scan_timing.hold_ticks  = csr_data;
               default: ;
            endcase
         end
      end
   end

   // result side: long hold-offs on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_style = $urandom_range(0, 3);
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 9) >= 3);
            2:       rsp_tready <= (rx_cycle % 7 != 2) && (rx_cycle % 7 != 5);
            default: rsp_tready <= (rx_cycle % 13 < 8);
         endcase
      end
   end

   task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                            input logic [CODE_W-1:0] code);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 5) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, code, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_word(OP_TICK, POS_W'($urandom_range(0, 7)),
                           CODE_W'($urandom_range(0, 15)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_timing(input logic [TICK_W-1:0] blank, input logic [TICK_W-1:0] setup,
                             input logic [TICK_W-1:0] hold);
      wait_drained();
      write_reg(CSR_BLANK_TICKS, blank);
      write_reg(CSR_SETUP_TICKS, setup);
      write_reg(CSR_HOLD_TICKS, hold);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [TICK_W-1:0] rand_ticks();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return TICK_W'($urandom_range(7, 40));
         default: return TICK_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic test_reset_state();
      send_ticks(20);
   endtask

   task automatic test_glyph_table();
      set_timing(1, 1, 1);
      for (int i = 0; i < NUM_DIGITS; i++) send_word(OP_WRITE, POS_W'(i), CODE_W'(i));
      send_ticks(3 * NUM_DIGITS);
      for (int i = 0; i < NUM_DIGITS; i++) send_word(OP_WRITE, POS_W'(i), CODE_W'(i + 8));
      send_ticks(3 * NUM_DIGITS);
   endtask

   task automatic test_zero_lengths();
      set_timing(0, 0, 0);
      send_ticks(6);
   endtask

   task automatic test_lowered_phase();
      set_timing('1, '1, '1);
      send_ticks(4);
      set_timing(1, '1, '1);
      send_ticks(3);
      set_timing(1, 1, '1);
      send_ticks(3);
      set_timing(1, 1, 1);
      send_ticks(3);
   endtask

   task automatic test_backpressure();
      set_timing(2, 1, 3);
      gaps_on      = 1'b0;
      hold_request = 120;
      repeat (60) begin
         if ($urandom_range(0, 3) == 0)
            send_word(OP_WRITE, POS_W'($urandom_range(0, 7)), CODE_W'($urandom_range(0, 15)));
         else
            send_ticks(1);
      end
      gaps_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random_scan();
      int unsigned n;
      for (int p = 0; p < 12; p++) begin
         set_timing(rand_ticks(), rand_ticks(), rand_ticks());
         gaps_on = (p % 4 != 3);
         n = $urandom_range(110, 170);
         repeat (n) begin
            if ($urandom_range(0, 9) < 3)
               send_word(OP_WRITE, POS_W'($urandom_range(0, 7)),
                         CODE_W'($urandom_range(0, 15)));
            else
               send_ticks(1);
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      scan_timing = '{blank_ticks: BLANK_TICKS_RST, setup_ticks: SETUP_TICKS_RST,
                      hold_ticks: HOLD_TICKS_RST};
      for (int i = 0; i < NUM_DIGITS; i++) glyph_store[i] = CODE_BLANK;
      scan_phase  = PH_BLANK;
      phase_ticks = 0;
      scan_pos    = '0;
      seg_latch   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_glyph_table();
      test_zero_lengths();
      test_lowered_phase();
      test_backpressure();
      test_random_scan();
      wait_drained();
      if (error_count == 0 && pending_drives.size() == 0) begin
         $display("tb_seven_segment_scan_controller: clean");
      end else begin
         $display("tb_seven_segment_scan_controller: errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ssc_pkg.sv
rtl/ssc_digit_store.sv
rtl/ssc_scan_engine.sv
rtl/seven_segment_scan_controller.sv
bench/tb_seven_segment_scan_controller.sv
